[rtl/dhs_pkg.sv]
// Shared types and constants of the disconnect handshake sender.
package dhs_pkg;

    localparam int BYTE_W    = 8;
    localparam int TIMER_W   = 16;
    localparam int RETRY_W   = 3;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int REC_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int FRAME_LEN = 5;
    localparam int BEAT_W    = $clog2(FRAME_LEN);

    // Operation codes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    // Phase codes, also reported as status
    localparam logic [STATUS_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [STATUS_W-1:0] PH_WAIT   = 2'd1;
    localparam logic [STATUS_W-1:0] PH_CLOSED = 2'd2;
    localparam logic [STATUS_W-1:0] PH_FAILED = 2'd3;

    // Recognizer states
    localparam logic [REC_W-1:0] REC_HUNT = 3'd0;
    localparam logic [REC_W-1:0] REC_FLAG = 3'd1;
    localparam logic [REC_W-1:0] REC_ADDR = 3'd2;
    localparam logic [REC_W-1:0] REC_CTRL = 3'd3;
    localparam logic [REC_W-1:0] REC_CHK  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_CTRL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UA_CTRL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIES   = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0]  flag;
        logic [BYTE_W-1:0]  address;
        logic [BYTE_W-1:0]  disc_ctrl;
        logic [BYTE_W-1:0]  ua_ctrl;
        logic [TIMER_W-1:0] timeout;
        logic [RETRY_W-1:0] max_retries;
    } cfg_t;

    // Result job handed from the protocol engine to the beat serializer
    typedef struct packed {
        logic                send;
        logic [BYTE_W-1:0]   ctrl;
        logic [STATUS_W-1:0] status;
    } job_t;

endpackage

[rtl/dhs_if.sv]
// Channel interfaces: input items, result beats and configuration writes.
interface dhs_in_if;
    logic                       valid;
    logic                       ready;
    logic [dhs_pkg::OP_W-1:0]   operation;
    logic [dhs_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface dhs_out_if;
    logic                         valid;
    logic                         ready;
    logic [dhs_pkg::BYTE_W-1:0]   tx_byte;
    logic                         tx_valid;
    logic                         last;
    logic [dhs_pkg::STATUS_W-1:0] status;

    modport source (output valid, output tx_byte, output tx_valid, output last,
                    output status, input ready);
    modport sink   (input valid, input tx_byte, input tx_valid, input last,
                    input status, output ready);
endinterface

interface dhs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dhs_pkg::CFG_IDX_W-1:0] index;
    logic [dhs_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/disconnect_handshake_sender_top.sv]
// Top level of the disconnect handshake sender: channels, config and beat output.
//
// Usage:
//   in_ch  : one item per beat (operation: start close, received byte, timer
//            tick; rx_byte). An item lands in an input register, and moves
//            into the protocol engine as soon as the beat serializer is free.
//   out_ch : result beats (tx_byte, tx_valid, last, status). A start, a resend
//            or a UA reply gives five beats carrying the frame bytes
//            (flag, address, control, address XOR control, flag); any other
//            item gives one beat with tx_valid low. last marks the final beat
//            of each item; status is the phase after that item.
//   cfg    : register writes (index, data), always ready; write only while
//            the block is idle.
// Timing: an accepted item passes through the input register into the serializer
// registers, and its first beat is offered from those. The serializer gives one
// beat per cycle while out_ch is ready; the input register takes the next item
// while the current one is still being sent.
// Reset: registers return to their defaults, the phase to idle, nothing held.
// Stall: when out_ch is not ready the current beat holds; the input register
// fills with one more item and then in_ch drops ready.
module disconnect_handshake_sender_top (
    input  logic      clk,
    input  logic      rst_n,
    dhs_in_if.sink    in_ch,
    dhs_out_if.source out_ch,
    dhs_cfg_if.sink   cfg
);
    import dhs_pkg::*;

    // Configuration registers
    cfg_t cfg_reg;

    // Input register
    logic              item_valid_reg;
    logic [OP_W-1:0]   item_op_reg;
    logic [BYTE_W-1:0] item_byte_reg;

    // Beat serializer
    logic                job_valid_reg;
    logic                job_send_reg;
    logic [BYTE_W-1:0]   job_ctrl_reg;
    logic [STATUS_W-1:0] job_status_reg;
    logic [BEAT_W-1:0]   beat_idx_reg;

    job_t job;
    logic in_fire;
    logic out_fire;
    logic last_beat;
    logic job_done;
    logic job_free;
    logic move;

    assign cfg.ready = 1'b1;

    // Write a configuration register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag        <= 8'h7E;
            cfg_reg.address     <= 8'h03;
            cfg_reg.disc_ctrl   <= 8'h0B;
            cfg_reg.ua_ctrl     <= 8'h07;
            cfg_reg.timeout     <= 16'd3000;
            cfg_reg.max_retries <= 3'd3;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_FLAG:      cfg_reg.flag        <= cfg.data[BYTE_W-1:0];
                CFG_ADDRESS:   cfg_reg.address     <= cfg.data[BYTE_W-1:0];
                CFG_DISC_CTRL: cfg_reg.disc_ctrl   <= cfg.data[BYTE_W-1:0];
                CFG_UA_CTRL:   cfg_reg.ua_ctrl     <= cfg.data[BYTE_W-1:0];
                CFG_TIMEOUT:   cfg_reg.timeout     <= cfg.data[TIMER_W-1:0];
                CFG_RETRIES:   cfg_reg.max_retries <= cfg.data[RETRY_W-1:0];
                default:       ;
            endcase
        end
    end

    // Handshake bookkeeping: the serializer frees on the last beat taken,
    // and the held item moves into the engine in that same cycle.
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_fire    = out_ch.valid && out_ch.ready;
    assign last_beat   = !job_send_reg || (beat_idx_reg == BEAT_W'(FRAME_LEN - 1));
    assign job_done    = out_fire && last_beat;
    assign job_free    = !job_valid_reg || job_done;
    assign move        = item_valid_reg && job_free;
    assign in_ch.ready = !item_valid_reg || move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_op_reg   <= in_ch.operation;
            item_byte_reg <= in_ch.rx_byte;
        end
    end

    // Protocol state advances once per item, as the item moves
    dhs_proto u_proto (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (move),
        .op      (item_op_reg),
        .rx_byte (item_byte_reg),
        .cfg     (cfg_reg),
        .job     (job)
    );

    // Serializer control: load a job, advance a beat per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            beat_idx_reg  <= '0;
        end
        else if (move)
        begin
            job_valid_reg <= 1'b1;
            beat_idx_reg  <= '0;
        end
        else if (job_done)
        begin
            job_valid_reg <= 1'b0;
            beat_idx_reg  <= '0;
        end
        else if (out_fire)
        begin
            beat_idx_reg <= beat_idx_reg + BEAT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            job_send_reg   <= job.send;
            job_ctrl_reg   <= job.ctrl;
            job_status_reg <= job.status;
        end
    end

    // Frame byte of the beat; the user keeps config stable while busy (unchecked)
    always_comb
    begin
        out_ch.tx_byte = '0;
        if (job_send_reg)
        begin
            unique case (beat_idx_reg)
                BEAT_W'(1): out_ch.tx_byte = cfg_reg.address;
                BEAT_W'(2): out_ch.tx_byte = job_ctrl_reg;
                BEAT_W'(3): out_ch.tx_byte = cfg_reg.address ^ job_ctrl_reg;
                default:    out_ch.tx_byte = cfg_reg.flag;
            endcase
        end
    end

    assign out_ch.valid    = job_valid_reg;
    assign out_ch.tx_valid = job_send_reg;
    assign out_ch.last     = last_beat;
    assign out_ch.status   = job_status_reg;

    // An idle serializer sits at the first beat
    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid_reg |-> beat_idx_reg == '0)
        else $error("beat index not at start while serializer idle");

    // Beat index never runs past the frame
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> beat_idx_reg < BEAT_W'(FRAME_LEN))
        else $error("beat index beyond frame length");

    // Single-beat results never advance the index
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !job_send_reg |-> beat_idx_reg == '0)
        else $error("beat index moved on a single-beat result");

    // A moved item is always offered on the next cycle
    a_move_loads: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> job_valid_reg && beat_idx_reg == '0)
        else $error("moved item not loaded into serializer");

    // Finishing a job with nothing waiting leaves the serializer empty
    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_done && !item_valid_reg |=> !job_valid_reg)
        else $error("serializer stayed busy after its last beat");

endmodule

[rtl/dhs_proto.sv]
// Protocol engine: phase, recognizer, resend count and reply timer.
module dhs_proto (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [dhs_pkg::OP_W-1:0]   op,
    input  logic [dhs_pkg::BYTE_W-1:0] rx_byte,
    input  dhs_pkg::cfg_t              cfg,
    output dhs_pkg::job_t              job
);
    import dhs_pkg::*;

    logic [STATUS_W-1:0] phase_reg, phase_next;
    logic [REC_W-1:0]    rec_reg, rec_next;
    logic [RETRY_W-1:0]  resend_reg, resend_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic                armed_reg, armed_next;
    logic [REC_W-1:0]    rec_adv;
    logic                rec_done;
    logic [BYTE_W-1:0]   disc_check;

    assign disc_check = cfg.address ^ cfg.disc_ctrl;

    // Advance the frame recognizer by one received byte
    always_comb
    begin
        rec_adv  = REC_HUNT;
        rec_done = 1'b0;
        unique case (rec_reg)
            REC_FLAG:
            begin
                if (rx_byte == cfg.address)   rec_adv = REC_ADDR;
                else if (rx_byte == cfg.flag) rec_adv = REC_FLAG;
            end
            REC_ADDR:
            begin
                if (rx_byte == cfg.disc_ctrl) rec_adv = REC_CTRL;
                else if (rx_byte == cfg.flag) rec_adv = REC_FLAG;
            end
            REC_CTRL:
            begin
                if (rx_byte == disc_check)    rec_adv = REC_CHK;
                else if (rx_byte == cfg.flag) rec_adv = REC_FLAG;
            end
            REC_CHK:
            begin
                if (rx_byte == cfg.flag) rec_done = 1'b1;
            end
            default:
            begin
                if (rx_byte == cfg.flag) rec_adv = REC_FLAG;
            end
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        rec_next    = rec_reg;
        resend_next = resend_reg;
        timer_next  = timer_reg;
        armed_next  = armed_reg;
        job.send    = 1'b0;
        job.ctrl    = cfg.disc_ctrl;
        if (op == OP_START)
        begin
            phase_next  = PH_WAIT;
            rec_next    = REC_HUNT;
            resend_next = '0;
            timer_next  = cfg.timeout;
            armed_next  = 1'b1;
            job.send    = 1'b1;
        end
        else if (op == OP_BYTE && phase_reg == PH_WAIT)
        begin
            armed_next = 1'b0;
            timer_next = '0;
            rec_next   = rec_adv;
            if (rec_done)
            begin
                phase_next = PH_CLOSED;
                job.send   = 1'b1;
                job.ctrl   = cfg.ua_ctrl;
            end
        end
        else if (op == OP_TICK && phase_reg == PH_WAIT && armed_reg)
        begin
            if (timer_reg <= TIMER_W'(1))
            begin
                if (resend_reg < cfg.max_retries)
                begin
                    resend_next = resend_reg + RETRY_W'(1);
                    timer_next  = cfg.timeout;
                    job.send    = 1'b1;
                end
                else
                begin
                    phase_next = PH_FAILED;
                    armed_next = 1'b0;
                    timer_next = '0;
                end
            end
            else
            begin
                timer_next = timer_reg - TIMER_W'(1);
            end
        end
        job.status = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            rec_reg    <= REC_HUNT;
            resend_reg <= '0;
            timer_reg  <= '0;
            armed_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            rec_reg    <= rec_next;
            resend_reg <= resend_next;
            timer_reg  <= timer_next;
            armed_reg  <= armed_next;
        end
    end

endmodule
